>>> src/mandelbrot_escape_time_pixel_top_assert.svh
// Assertion macros shared by the escape-time pixel engine.
// Each macro checks an implication on the rising edge of the given clock,
// and is disabled while the active-low reset is asserted.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MET_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MET_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MET_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define MET_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> src/met_pkg.sv
package met_pkg;

    // Field and arithmetic widths.
    localparam int PIX_W      = 8;
    localparam int OUT_W      = 10;
    localparam int Q_W        = 32;
    localparam int FRAC_BITS  = 28;
    localparam int SPAN_W     = Q_W + 1;
    localparam int MAG_W      = PIX_W + Q_W;
    localparam int WIDE_W     = MAG_W + 2;
    localparam int PROD_W     = 2 * Q_W;
    localparam int CFG_ADDR_W = 2;
    localparam int S_DATA_W   = 2 * PIX_W;
    localparam int M_DATA_W   = 24;

    // Escape threshold: 4.0 in Q8.56.
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);

    // Window reset values in Q4.28.
    localparam logic signed [Q_W-1:0] REAL_MIN_RST = -32'sd536870912;
    localparam logic signed [Q_W-1:0] REAL_MAX_RST = 32'sd268435456;
    localparam logic signed [Q_W-1:0] IMAG_MIN_RST = -32'sd402653184;
    localparam logic signed [Q_W-1:0] IMAG_MAX_RST = 32'sd402653184;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REAL_MIN = 2'd0,
        REG_REAL_MAX = 2'd1,
        REG_IMAG_MIN = 2'd2,
        REG_IMAG_MAX = 2'd3
    } met_reg_idx_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV,
        ST_MAP,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } met_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic div_start;
        logic map;
        logic mul;
        logic step;
        logic out_load;
    } met_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic at_limit;
        logic escaped;
    } met_sts_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic all_ones;
        logic any_ones;
        logic signed [Q_W-1:0] r;
        all_ones = &v[WIDE_W-1:Q_W-1];
        any_ones = |v[WIDE_W-1:Q_W-1];
        if (v[WIDE_W-1] && !all_ones) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else if (!v[WIDE_W-1] && any_ones) begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/met_div.sv
module met_div
    import met_pkg::*;
#(
    parameter int IMAGE_SIZE = 255
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    output logic [MAG_W-1:0] quotient,
    output logic             done
);

    // Reciprocal of the image size scaled by 2^MAG_W, used in two halves.
    localparam int HALF_W = MAG_W / 2;
    localparam int LO_W   = MAG_W + HALF_W;
    localparam int ACC_W  = 2 * MAG_W;
    localparam int STAGES = 3;
    localparam longint unsigned RECIP = (64'd1 << MAG_W) / 64'(IMAGE_SIZE);
    localparam logic [HALF_W-1:0] RECIP_LO = HALF_W'(RECIP);
    localparam logic [HALF_W-1:0] RECIP_HI = HALF_W'(RECIP >> HALF_W);
    localparam logic [MAG_W-1:0]  DIVISOR  = MAG_W'(IMAGE_SIZE);

    logic [MAG_W-1:0]  n_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [MAG_W-1:0]  est_reg;
    logic [MAG_W-1:0]  quot_reg;
    logic [STAGES-1:0] stage_reg;
    logic [LO_W-1:0]   lo_prod;
    logic [LO_W-1:0]   hi_prod;
    logic [ACC_W-1:0]  acc_sum;
    logic [MAG_W-1:0]  rem;
    logic              fix;

    // Partial products of the dividend with the two reciprocal halves.
    assign lo_prod = {{HALF_W{1'b0}}, n_reg} * {{MAG_W{1'b0}}, RECIP_LO};
    assign hi_prod = {{HALF_W{1'b0}}, n_reg} * {{MAG_W{1'b0}}, RECIP_HI};
    assign acc_sum = acc_reg + {hi_prod, {HALF_W{1'b0}}};

    // The estimate is at most one below the true quotient; the remainder tells.
    // The true remainder is below twice the divisor, so the low bits suffice.
    assign rem = n_reg - est_reg * DIVISOR;
    assign fix = (rem >= DIVISOR);

    // Stage tracker: one bit walks through the three steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else if (start) begin
            stage_reg <= STAGES'(1);
        end else begin
            stage_reg <= {stage_reg[STAGES-2:0], 1'b0};
        end
    end

    // Low product, then high product and estimate, then the correction.
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= dividend;
        end
        if (stage_reg[0]) begin
            acc_reg <= {{HALF_W{1'b0}}, lo_prod};
        end
        if (stage_reg[1]) begin
            est_reg <= acc_sum[ACC_W-1:MAG_W];
        end
        if (stage_reg[2]) begin
            quot_reg <= est_reg + MAG_W'(fix);
        end
    end

    assign quotient = quot_reg;
    assign done     = (stage_reg == '0);

endmodule

>>> src/met_ctrl.sv
`include "mandelbrot_escape_time_pixel_top_assert.svh"

module met_ctrl
    import met_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  met_sts_t sts,
    output met_cmd_t cmd
);

    met_state_t state_reg;
    met_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    // The result register can take a new value when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_MAP;
            end
            ST_MAP: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = sts.at_limit ? ST_DONE : ST_STEP;
            end
            ST_STEP: begin
                state_next = sts.escaped ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.capture   = s_tvalid;
            ST_SCALE: cmd.div_start = 1'b1;
            ST_DIV:   cmd           = '0;
            ST_MAP:   cmd.map       = 1'b1;
            ST_MUL:   cmd.mul       = !sts.at_limit;
            ST_STEP:  cmd.step      = !sts.escaped;
            ST_DONE:  cmd.out_load  = out_free;
        endcase
    end

    // Result valid flag.
    assign m_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // A waiting result is never overwritten.
    `MET_ASSERT_IMP(a_out_no_overwrite, aclk, aresetn, cmd.out_load, out_free, "result overwritten")
    // The mapping waits for both divisions.
    `MET_ASSERT_NXT(a_div_wait, aclk, aresetn, (state_reg == ST_DIV) && !sts.div_done, state_reg == ST_DIV, "left division early")
    // No update after the escape test has fired.
    `MET_ASSERT_IMP(a_no_step_escaped, aclk, aresetn, cmd.step, !sts.escaped, "update after escape")
    // No iteration beyond the limit.
    `MET_ASSERT_IMP(a_no_mul_limit, aclk, aresetn, cmd.mul, !sts.at_limit, "iteration past limit")

endmodule

>>> src/met_dp.sv
module met_dp
    import met_pkg::*;
#(
    parameter int IMAGE_SIZE     = 255,
    parameter int MAX_ITERATIONS = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [Q_W-1:0]        cfg_wdata,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  met_cmd_t              cmd,
    output met_sts_t              sts,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int CW = $clog2(MAX_ITERATIONS + 1);

    logic signed [Q_W-1:0] real_min_reg;
    logic signed [Q_W-1:0] real_max_reg;
    logic signed [Q_W-1:0] imag_min_reg;
    logic signed [Q_W-1:0] imag_max_reg;

    logic [PIX_W-1:0] col_reg;
    logic [PIX_W-1:0] row_reg;

    logic signed [SPAN_W-1:0] span_re;
    logic signed [SPAN_W-1:0] span_im;
    logic signed [WIDE_W-1:0] prod_re;
    logic signed [WIDE_W-1:0] prod_im;
    logic signed [WIDE_W-1:0] abs_re;
    logic signed [WIDE_W-1:0] abs_im;
    logic                     neg_re_reg;
    logic                     neg_im_reg;
    logic [MAG_W-1:0]         quot_re;
    logic [MAG_W-1:0]         quot_im;
    logic                     done_re;
    logic                     done_im;

    logic signed [WIDE_W-1:0] q_re;
    logic signed [WIDE_W-1:0] q_im;
    logic signed [WIDE_W-1:0] sum_re;
    logic signed [WIDE_W-1:0] sum_im;

    logic signed [Q_W-1:0]    cx_reg;
    logic signed [Q_W-1:0]    cy_reg;
    logic signed [Q_W-1:0]    x_reg;
    logic signed [Q_W-1:0]    y_reg;
    logic signed [Q_W-1:0]    x_next;
    logic signed [Q_W-1:0]    y_next;
    logic signed [PROD_W-1:0] xx_reg;
    logic signed [PROD_W-1:0] yy_reg;
    logic signed [PROD_W-1:0] xy_reg;
    logic [PROD_W-1:0]        mag2;
    logic signed [WIDE_W-1:0] nx;
    logic signed [WIDE_W-1:0] ny;

    logic [CW-1:0]       count_reg;
    logic [CW+OUT_W-1:0] count_ext;
    logic [OUT_W-1:0]    iter_reg;
    logic [OUT_W-1:0]    gray_reg;

    // Window registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_min_reg <= REAL_MIN_RST;
            real_max_reg <= REAL_MAX_RST;
            imag_min_reg <= IMAG_MIN_RST;
            imag_max_reg <= IMAG_MAX_RST;
        end else if (cfg_we) begin
            unique case (met_reg_idx_t'(cfg_addr))
                REG_REAL_MIN: real_min_reg <= cfg_wdata;
                REG_REAL_MAX: real_max_reg <= cfg_wdata;
                REG_IMAG_MIN: imag_min_reg <= cfg_wdata;
                REG_IMAG_MAX: imag_max_reg <= cfg_wdata;
            endcase
        end
    end

    // Pixel capture on the accepted input beat.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            col_reg <= s_tdata[PIX_W-1:0];
            row_reg <= s_tdata[S_DATA_W-1:PIX_W];
        end
    end

    // Scale: pixel times window span, split into sign and magnitude.
    assign span_re = SPAN_W'(real_max_reg) - SPAN_W'(real_min_reg);
    assign span_im = SPAN_W'(imag_max_reg) - SPAN_W'(imag_min_reg);
    assign prod_re = $signed({{(WIDE_W-PIX_W){1'b0}}, col_reg}) * WIDE_W'(span_re);
    assign prod_im = $signed({{(WIDE_W-PIX_W){1'b0}}, row_reg}) * WIDE_W'(span_im);
    assign abs_re  = prod_re[WIDE_W-1] ? -prod_re : prod_re;
    assign abs_im  = prod_im[WIDE_W-1] ? -prod_im : prod_im;

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_re_reg <= prod_re[WIDE_W-1];
            neg_im_reg <= prod_im[WIDE_W-1];
        end
    end

    // Truncating division by the image size, one lane per axis.
    met_div #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_div_re (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (abs_re[MAG_W-1:0]),
        .quotient (quot_re),
        .done     (done_re)
    );

    met_div #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_div_im (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (abs_im[MAG_W-1:0]),
        .quotient (quot_im),
        .done     (done_im)
    );

    // Map: restore the sign, add the window edge, saturate.
    assign q_re   = neg_re_reg ? -$signed({2'b00, quot_re}) : $signed({2'b00, quot_re});
    assign q_im   = neg_im_reg ? -$signed({2'b00, quot_im}) : $signed({2'b00, quot_im});
    assign sum_re = WIDE_W'(real_min_reg) + q_re;
    assign sum_im = WIDE_W'(imag_min_reg) + q_im;

    // Iteration products, registered before the update.
    assign mag2   = xx_reg + yy_reg;
    assign nx     = $signed({{(WIDE_W-(PROD_W-1-FRAC_BITS)){1'b0}}, xx_reg[PROD_W-2:FRAC_BITS]})
                  - $signed({{(WIDE_W-(PROD_W-1-FRAC_BITS)){1'b0}}, yy_reg[PROD_W-2:FRAC_BITS]})
                  + WIDE_W'(cx_reg);
    assign ny     = $signed({{(WIDE_W-(PROD_W-FRAC_BITS+1)){xy_reg[PROD_W-1]}},
                             xy_reg[PROD_W-1:FRAC_BITS-1]})
                  + WIDE_W'(cy_reg);
    assign x_next = sat32(nx);
    assign y_next = sat32(ny);

    always_ff @(posedge aclk) begin
        if (cmd.map) begin
            cx_reg <= sat32(sum_re);
            cy_reg <= sat32(sum_im);
            x_reg  <= '0;
            y_reg  <= '0;
        end else if (cmd.step) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
        end
        if (cmd.mul) begin
            xx_reg <= PROD_W'(x_reg) * PROD_W'(x_reg);
            yy_reg <= PROD_W'(y_reg) * PROD_W'(y_reg);
            xy_reg <= PROD_W'(x_reg) * PROD_W'(y_reg);
        end
    end

    // Iteration counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.map) begin
            count_reg <= '0;
        end else if (cmd.step) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // Result register: count and gray level, both masked to the field width.
    assign count_ext = {{OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            iter_reg <= count_ext[OUT_W-1:0];
            gray_reg <= sts.at_limit ? '0 : count_ext[OUT_W-1:0];
        end
    end

    assign sts.div_done = done_re && done_im;
    assign sts.at_limit = (count_reg == CW'(MAX_ITERATIONS));
    assign sts.escaped  = (mag2 >= ESCAPE_LIMIT);

    assign m_tdata = {{(M_DATA_W-2*OUT_W){1'b0}}, gray_reg, iter_reg};

endmodule

>>> src/mandelbrot_escape_time_pixel_top.sv
// One pixel is in work at a time; the next can be taken in the cycle after the result is
// loaded. The multiply and update loop sets the rate; scaling, a divide by the image size
// and the mapping come before it. Result stalls hold the finished pixel.
// Reset (aresetn, synchronous, active low) restores the default window and empties the block.
module mandelbrot_escape_time_pixel_top
    import met_pkg::*;
#(
    parameter int IMAGE_SIZE     = 255,
    parameter int MAX_ITERATIONS = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [Q_W-1:0]        cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // pixel_col[7:0], pixel_row[15:8]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // iteration_count[9:0], gray_level[19:10]
);

    met_cmd_t cmd;
    met_sts_t sts;

    // Sequencer.
    met_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and result storage.
    met_dp #(
        .IMAGE_SIZE     (IMAGE_SIZE),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule
